// ----- rtl/fbc64_pkg.sv -----
// Shared constants, types, round function and key selection of the 64-bit Feistel block cipher.
package fbc64_pkg;

   localparam int WORD_W        = 32;
   localparam int BLOCK_W       = 64;
   localparam int NUM_ROUNDS    = 32;
   localparam int CYCLIC_ROUNDS = 24;
   localparam int KEY_WORDS     = 8;
   localparam int KEY_SEL_W     = $clog2(KEY_WORDS);
   localparam int ROT_LEFT      = 11;
   localparam int NIBBLES       = WORD_W / 4;
   localparam int CSR_INDEX_W   = 8;

   typedef logic [WORD_W-1:0] word_type;

   // One pipeline slot: valid bit plus the two halves in flight.
   typedef struct packed {
      logic     valid;
      word_type left;
      word_type right;
   } stage_type;

   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
        4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
      '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
        4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
      '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
        4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
      '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
        4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
      '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
        4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
      '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
        4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
        4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
      '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
        4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
   };

   // Add key, substitute each nibble through its own box, rotate left.
   function automatic word_type round_f(input word_type half, input word_type key);
      word_type sum;
      word_type sub;
      sum = half + key;
      for (int n = 0; n < NIBBLES; n++) begin
         sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
      end
      return {sub[WORD_W-ROT_LEFT-1:0], sub[WORD_W-1:WORD_W-ROT_LEFT]};
   endfunction

   // Key word for a round: cyclic through the first rounds, reversed afterwards.
   function automatic logic [KEY_SEL_W-1:0] key_sel(input int unsigned rnd);
      logic [KEY_SEL_W-1:0] idx;
      idx = rnd[KEY_SEL_W-1:0];
      return (rnd < CYCLIC_ROUNDS) ? idx : ~idx;
   endfunction

endpackage

// ----- rtl/fbc64_round.sv -----
// One registered Feistel round stage of the cipher pipeline.
module fbc64_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 last_round,
   input  fbc64_pkg::word_type  key,
   input  fbc64_pkg::stage_type up_stage,
   output fbc64_pkg::stage_type dn_stage
);
   import fbc64_pkg::*;

   stage_type stage_ff;
   stage_type stage_in;
   word_type  mixed;

   always_comb begin
      mixed          = up_stage.left ^ round_f(up_stage.right, key);
      stage_in.valid = up_stage.valid;
      if (last_round) begin
         // final round keeps the halves in place
         stage_in.left  = mixed;
         stage_in.right = up_stage.right;
      end else begin
         stage_in.left  = up_stage.right;
         stage_in.right = mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_stage = stage_ff;

endmodule

// ----- rtl/feistel_block_cipher_64_unit.sv -----
// Top level: 32-stage pipelined 64-bit Feistel block cipher with key registers.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata[63:0] plain_block
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[63:0] cipher_block
//  csr      in         csr_valid/csr_ready    csr_index[7:0], csr_data[31:0]
//
// One round per register stage: 32 stages, so a request taken by the pipe
// passes through every round register before its result reaches the output;
// one request is taken every cycle while the output is not stalled.
// The last stage is the output register; when it holds an untaken result,
// the whole pipe freezes and req_tready drops in the same cycle.
// Reset clears all stage valid bits and the eight key words to zero.
// Key writes to indexes beyond 7 are taken and dropped.
module feistel_block_cipher_64_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fbc64_pkg::BLOCK_W-1:0]       req_tdata,  // [63:0] plain_block
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fbc64_pkg::BLOCK_W-1:0]       rsp_tdata,  // [63:0] cipher_block
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fbc64_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fbc64_pkg::WORD_W-1:0]        csr_data
);
   import fbc64_pkg::*;

   word_type  key_ff [KEY_WORDS];
   stage_type chain [NUM_ROUNDS+1];
   logic      enable;
   logic [NUM_ROUNDS-1:0] valid_vec;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_INDEX_W'(KEY_WORDS))) begin
         key_ff[csr_index[KEY_SEL_W-1:0]] <= csr_data;
      end
   end

   // advance everything unless the output holds an untaken result
   assign enable     = !chain[NUM_ROUNDS].valid || rsp_tready;
   assign req_tready = enable;

   assign chain[0].valid = req_tvalid;
   assign chain[0].left  = req_tdata[BLOCK_W-1:WORD_W];
   assign chain[0].right = req_tdata[WORD_W-1:0];

   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      fbc64_round u_round (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .last_round (1'(r == NUM_ROUNDS-1)),
         .key        (key_ff[key_sel(r)]),
         .up_stage   (chain[r]),
         .dn_stage   (chain[r+1])
      );
      assign valid_vec[r] = chain[r+1].valid;
   end

   assign rsp_tvalid = chain[NUM_ROUNDS].valid;
   assign rsp_tdata  = {chain[NUM_ROUNDS].left, chain[NUM_ROUNDS].right};

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output result is stalled");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_vec[0])
      else $error("accepted request missing from first stage");

   a_last_stage_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (enable && valid_vec[NUM_ROUNDS-2]) |=> rsp_tvalid)
      else $error("result lost between final stages");

   a_hold_keeps_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(valid_vec))
      else $error("pipeline moved during output stall");

endmodule
